>>> rtl/sli_pkg.sv
// Shared types and constants for the sorted list intersect/union block.
`timescale 1ns / 1ps

package sli_pkg;

    localparam int ID_W   = 31;
    localparam int FUNC_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_LOAD_A = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_B = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RUN    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CMP,
        ST_FLUSH
    } state_t;

endpackage

>>> rtl/sli_if.sv
// Valid/ready channel interfaces for load/run items and result items.
`timescale 1ns / 1ps

interface sli_in_if;
    logic                       valid;
    logic                       ready;
    logic [sli_pkg::FUNC_W-1:0] func;
    logic [sli_pkg::ID_W-1:0]   doc_id;

    modport source (output valid, output func, output doc_id, input ready);
    modport sink   (input valid, input func, input doc_id, output ready);
endinterface

interface sli_out_if;
    logic                     valid;
    logic                     ready;
    logic [sli_pkg::ID_W-1:0] result_id;
    logic                     is_last;
    logic                     none;
    logic                     overflowed;

    modport source (output valid, output result_id, output is_last, output none,
                    output overflowed, input ready);
    modport sink   (input valid, input result_id, input is_last, input none,
                    input overflowed, output ready);
endinterface

>>> rtl/sli_list_mem.sv
// One list store: single write port, single registered read port.
`timescale 1ns / 1ps

module sli_list_mem #(
    parameter int DEPTH = 32
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [$clog2(DEPTH)-1:0]     waddr,
    input  logic [sli_pkg::ID_W-1:0]     wdata,
    input  logic [$clog2(DEPTH)-1:0]     raddr,
    output logic [sli_pkg::ID_W-1:0]     rdata
);

    logic [sli_pkg::ID_W-1:0] mem [DEPTH];
    logic [sli_pkg::ID_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/sli_seq.sv
// Sequencer: list loading, two-pointer walk over a shared comparator, result staging.
`timescale 1ns / 1ps

module sli_seq #(
    parameter int LIST_DEPTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          union_mode,
    sli_in_if.sink                        req,
    sli_out_if.source                     rsp,
    output logic                          we_a,
    output logic                          we_b,
    output logic [$clog2(LIST_DEPTH)-1:0] waddr_a,
    output logic [$clog2(LIST_DEPTH)-1:0] waddr_b,
    output logic [$clog2(LIST_DEPTH)-1:0] raddr_a,
    output logic [$clog2(LIST_DEPTH)-1:0] raddr_b,
    input  logic [sli_pkg::ID_W-1:0]      rdata_a,
    input  logic [sli_pkg::ID_W-1:0]      rdata_b
);

    localparam int IDX_W = $clog2(LIST_DEPTH);
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LIST_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    sli_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]         cnt_a_reg, cnt_a_next;
    logic [CNT_W-1:0]         cnt_b_reg, cnt_b_next;
    logic                     ovf_reg, ovf_next;
    logic [CNT_W-1:0]         i_reg, i_next;
    logic [CNT_W-1:0]         j_reg, j_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic [sli_pkg::ID_W-1:0] pend_id_reg, pend_id_next;
    logic                     out_valid_reg, out_valid_next;
    logic [sli_pkg::ID_W-1:0] out_id_reg, out_id_next;
    logic                     out_last_reg, out_last_next;
    logic                     out_none_reg, out_none_next;
    logic                     out_ovf_reg, out_ovf_next;

    logic                     accept;
    logic                     have_a, have_b, walk_more;
    logic                     a_lt_b, a_eq_b;
    logic                     take_a, take_b, emit;
    logic [sli_pkg::ID_W-1:0] pick_id;
    logic                     stall, out_free;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    assign have_a    = i_reg < cnt_a_reg;
    assign have_b    = j_reg < cnt_b_reg;
    assign walk_more = union_mode ? (have_a || have_b) : (have_a && have_b);

    // Shared comparator for the walk.
    assign a_lt_b = rdata_a < rdata_b;
    assign a_eq_b = rdata_a == rdata_b;

    always_comb
    begin
        if (union_mode)
        begin
            take_a  = have_a && (!have_b || a_lt_b || a_eq_b);
            take_b  = have_b && (!have_a || !a_lt_b);
            pick_id = take_a ? rdata_a : rdata_b;
            emit    = !(pend_valid_reg && (pend_id_reg == pick_id));
        end
        else
        begin
            take_a  = a_lt_b || a_eq_b;
            take_b  = !a_lt_b;
            pick_id = rdata_a;
            emit    = a_eq_b;
        end
    end

    // Hold the walk while the staged item cannot move to a busy output register.
    assign stall = emit && pend_valid_reg && !out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sli_pkg::ST_IDLE:
            begin
                if (accept && (req.func == sli_pkg::FUNC_RUN))
                begin
                    state_next = sli_pkg::ST_FETCH;
                end
            end
            sli_pkg::ST_FETCH:
            begin
                state_next = walk_more ? sli_pkg::ST_CMP : sli_pkg::ST_FLUSH;
            end
            sli_pkg::ST_CMP:
            begin
                if (!stall)
                begin
                    state_next = sli_pkg::ST_FETCH;
                end
            end
            sli_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = sli_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sli_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_a_next      = cnt_a_reg;
        cnt_b_next      = cnt_b_reg;
        ovf_next        = ovf_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_id_next     = out_id_reg;
        out_last_next   = out_last_reg;
        out_none_next   = out_none_reg;
        out_ovf_next    = out_ovf_reg;
        we_a            = 1'b0;
        we_b            = 1'b0;

        case (state_reg)
            sli_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.func)
                        sli_pkg::FUNC_LOAD_A:
                        begin
                            if (cnt_a_reg < CNT_FULL)
                            begin
                                we_a       = 1'b1;
                                cnt_a_next = cnt_a_reg + CNT_ONE;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        sli_pkg::FUNC_LOAD_B:
                        begin
                            if (cnt_b_reg < CNT_FULL)
                            begin
                                we_b       = 1'b1;
                                cnt_b_next = cnt_b_reg + CNT_ONE;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        sli_pkg::FUNC_RUN:
                        begin
                            i_next          = '0;
                            j_next          = '0;
                            pend_valid_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            sli_pkg::ST_CMP:
            begin
                if (!stall)
                begin
                    if (take_a)
                    begin
                        i_next = i_reg + CNT_ONE;
                    end
                    if (take_b)
                    begin
                        j_next = j_reg + CNT_ONE;
                    end
                    if (emit)
                    begin
                        // Staged item is now known not to be the last one.
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_id_next    = pend_id_reg;
                            out_last_next  = 1'b0;
                            out_none_next  = 1'b0;
                            out_ovf_next   = ovf_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = pick_id;
                    end
                end
            end
            sli_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_id_next     = pend_valid_reg ? pend_id_reg : '0;
                    out_last_next   = 1'b1;
                    out_none_next   = !pend_valid_reg;
                    out_ovf_next    = ovf_reg;
                    cnt_a_next      = '0;
                    cnt_b_next      = '0;
                    ovf_next        = 1'b0;
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sli_pkg::ST_IDLE;
            cnt_a_reg      <= '0;
            cnt_b_reg      <= '0;
            ovf_reg        <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_a_reg      <= cnt_a_next;
            cnt_b_reg      <= cnt_b_next;
            ovf_reg        <= ovf_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_id_reg  <= pend_id_next;
        out_id_reg   <= out_id_next;
        out_last_reg <= out_last_next;
        out_none_reg <= out_none_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign req.ready      = state_reg == sli_pkg::ST_IDLE;
    assign rsp.valid      = out_valid_reg;
    assign rsp.result_id  = out_id_reg;
    assign rsp.is_last    = out_last_reg;
    assign rsp.none       = out_none_reg;
    assign rsp.overflowed = out_ovf_reg;

    assign waddr_a = cnt_a_reg[IDX_W-1:0];
    assign waddr_b = cnt_b_reg[IDX_W-1:0];
    assign raddr_a = i_reg[IDX_W-1:0];
    assign raddr_b = j_reg[IDX_W-1:0];

endmodule

>>> rtl/sorted_list_intersect_union.sv
// Sorted list intersect/union: top level with mode register, list stores and sequencer.
//
// Usage: the req channel takes items with func/doc_id. func 0 appends doc_id to
// list A, func 1 to list B (each with no result item); a load into a full
// list is dropped and sets the overflow flag. func 2 runs the merge; func 3 is
// ignored. The rsp channel returns the answer in ascending order, is_last on the
// final item; an empty answer is one item with none set. cfg_we/cfg_wdata set
// union_mode (0 intersect, 1 deduplicated union); the user must write it only
// while the block is idle, as the block itself does not enforce this. A load is
// taken every cycle while the block is idle. A run repeats a walk step (registered
// read of both list stores in ST_FETCH, then one compare in ST_CMP), at most
// count_a + count_b steps, then an end check in ST_FETCH and a flush in
// ST_FLUSH. req.ready stays low for the whole run. A stalled receiver holds
// the output register and pauses the walk once the next item has to move out.
// Reset clears counts, overflow flag, union_mode and the sequencer; list contents
// are left as they are. Counts and the overflow flag clear at the end of every run.
`timescale 1ns / 1ps

module sorted_list_intersect_union #(
    parameter int LIST_DEPTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    sli_in_if.sink    req,
    sli_out_if.source rsp,
    input  logic      cfg_we,
    input  logic      cfg_wdata
);

    localparam int IDX_W = $clog2(LIST_DEPTH);

    logic                     union_mode_reg;
    logic                     we_a, we_b;
    logic [IDX_W-1:0]         waddr_a, waddr_b, raddr_a, raddr_b;
    logic [sli_pkg::ID_W-1:0] rdata_a, rdata_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            union_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            union_mode_reg <= cfg_wdata;
        end
    end

    sli_list_mem #(
        .DEPTH (LIST_DEPTH)
    ) u_list_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr_a),
        .wdata (req.doc_id),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    sli_list_mem #(
        .DEPTH (LIST_DEPTH)
    ) u_list_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr_b),
        .wdata (req.doc_id),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    sli_seq #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .union_mode (union_mode_reg),
        .req        (req),
        .rsp        (rsp),
        .we_a       (we_a),
        .we_b       (we_b),
        .waddr_a    (waddr_a),
        .waddr_b    (waddr_b),
        .raddr_a    (raddr_a),
        .raddr_b    (raddr_b),
        .rdata_a    (rdata_a),
        .rdata_b    (rdata_b)
    );

endmodule
